[rtl/assert_macros.svh]
// Assertion helpers for the RTL files; keypad_expression_editor.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KEE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("keypad editor assertion failed");
`define KEE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("keypad editor assertion failed");
`else
`define KEE_ASSERT(lbl, prop)
`define KEE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/kee_pkg.sv]
package kee_pkg;

  localparam int BufDepth = 32;
  localparam int AddrW    = $clog2(BufDepth);
  localparam int CntW     = $clog2(BufDepth + 1);
  localparam int QDepth   = 2;
  localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0] KeyShift = 8'h44;
  localparam logic [7:0] KeyA     = 8'h41;
  localparam logic [7:0] KeyB     = 8'h42;
  localparam logic [7:0] KeyC     = 8'h43;
  localparam logic [7:0] KeyHash  = 8'h23;
  localparam logic [7:0] Digit0   = 8'h30;
  localparam logic [7:0] Digit9   = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChMul    = 8'h78;
  localparam logic [7:0] ChDiv    = 8'h2F;
  localparam logic [7:0] ChDot    = 8'h2E;

  typedef enum logic [1:0] {
    CmdKey    = 2'd0,
    CmdClrErr = 2'd1,
    CmdRead   = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    OpNop,
    OpShift,
    OpDigit,
    OpKeyA,
    OpKeyB,
    OpKeyC,
    OpKeyHash,
    OpClrErr,
    OpRead
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       ch;
    logic [AddrW-1:0] idx;
  } entry_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_status_t;

  function automatic logic is_op(input logic [7:0] c);
    return (c == ChPlus) || (c == ChMinus) || (c == ChMul) || (c == ChDiv);
  endfunction

endpackage

[rtl/kee_front.sv]
module kee_front (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            in_cmd_i,
  input  logic [7:0]            in_key_i,
  input  logic [4:0]            in_read_index_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output kee_pkg::entry_t       q_entry_o
);

  kee_pkg::op_e key_op;

  always_comb begin
    if (in_key_i == kee_pkg::KeyShift) begin
      key_op = kee_pkg::OpShift;
    end else if (in_key_i >= kee_pkg::Digit0 && in_key_i <= kee_pkg::Digit9) begin
      key_op = kee_pkg::OpDigit;
    end else if (in_key_i == kee_pkg::KeyA) begin
      key_op = kee_pkg::OpKeyA;
    end else if (in_key_i == kee_pkg::KeyB) begin
      key_op = kee_pkg::OpKeyB;
    end else if (in_key_i == kee_pkg::KeyC) begin
      key_op = kee_pkg::OpKeyC;
    end else if (in_key_i == kee_pkg::KeyHash) begin
      key_op = kee_pkg::OpKeyHash;
    end else begin
      key_op = kee_pkg::OpNop;
    end
  end

  always_comb begin
    q_entry_o.ch  = in_key_i;
    q_entry_o.idx = in_read_index_i;
    case (kee_pkg::cmd_e'(in_cmd_i))
      kee_pkg::CmdKey:    q_entry_o.op = key_op;
      kee_pkg::CmdClrErr: q_entry_o.op = kee_pkg::OpClrErr;
      kee_pkg::CmdRead:   q_entry_o.op = kee_pkg::OpRead;
      default:            q_entry_o.op = kee_pkg::OpNop;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

[rtl/kee_fifo.sv]
module kee_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  kee_pkg::entry_t       entry_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output kee_pkg::entry_t       entry_o,
  output kee_pkg::q_status_t    status_o
);

  kee_pkg::entry_t                    slots_q [kee_pkg::QDepth];
  logic [kee_pkg::QPtrW-1:0]          wr_ptr_q, wr_ptr_d;
  logic [kee_pkg::QPtrW-1:0]          rd_ptr_q, rd_ptr_d;
  logic [kee_pkg::QCntW-1:0]          count_q, count_d;
  logic                               do_push, do_pop;

  assign do_push = push_i && (count_q != kee_pkg::QCntW'(kee_pkg::QDepth));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == kee_pkg::QPtrW'(kee_pkg::QDepth - 1)) ? '0
                 : wr_ptr_q + kee_pkg::QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == kee_pkg::QPtrW'(kee_pkg::QDepth - 1)) ? '0
                 : rd_ptr_q + kee_pkg::QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + kee_pkg::QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - kee_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  assign valid_o        = (count_q != '0);
  assign entry_o        = slots_q[rd_ptr_q];
  assign status_o.full  = (count_q == kee_pkg::QCntW'(kee_pkg::QDepth));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;

endmodule

[rtl/kee_back.sv]
module kee_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  kee_pkg::entry_t       q_entry_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [5:0]            out_length_o,
  output logic [7:0]            out_last_char_o,
  output logic                  out_shift_on_o,
  output logic                  out_error_o,
  output logic [7:0]            out_read_char_o
);

  localparam int CntW  = kee_pkg::CntW;
  localparam int AddrW = kee_pkg::AddrW;

  logic [7:0]      mem [kee_pkg::BufDepth];

  logic [CntW-1:0] fill_q, fill_d;
  logic            shift_q, shift_d;
  logic            err_q, err_d;
  logic [7:0]      last_q, last_d;
  logic [7:0]      prev_q, prev2_q, deep_q;

  logic            out_valid_q;
  logic [5:0]      out_len_q;
  logic [7:0]      out_last_q;
  logic            out_shift_q, out_err_q;
  logic            rd_en_q, rd_en_d;
  logic [7:0]      rd_data_q;

  logic            exec, full;
  logic            do_push, do_pop, do_clear;
  logic [7:0]      push_ch, op_ch;
  logic [AddrW-1:0] deep_addr;

  assign exec      = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o   = exec;
  assign full      = (fill_q == CntW'(kee_pkg::BufDepth));
  assign deep_addr = AddrW'(fill_q - CntW'(5));

  always_comb begin
    if (q_entry_i.op == kee_pkg::OpKeyA) begin
      op_ch = shift_q ? kee_pkg::ChMul : kee_pkg::ChPlus;
    end else begin
      op_ch = shift_q ? kee_pkg::ChDiv : kee_pkg::ChMinus;
    end
  end

  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_clear = 1'b0;
    push_ch  = q_entry_i.ch;
    shift_d  = shift_q;
    err_d    = err_q;
    rd_en_d  = 1'b0;
    case (q_entry_i.op)
      kee_pkg::OpShift: shift_d = ~shift_q;
      kee_pkg::OpDigit: do_push = !full;
      kee_pkg::OpKeyA, kee_pkg::OpKeyB: begin
        if (fill_q != '0 && kee_pkg::is_op(last_q)) begin
          err_d = 1'b1;
        end else begin
          do_push = !full;
          push_ch = op_ch;
        end
      end
      kee_pkg::OpKeyC: begin
        if (!shift_q) begin
          do_push = !full;
          push_ch = kee_pkg::ChDot;
        end
      end
      kee_pkg::OpKeyHash: begin
        if (shift_q) begin
          do_clear = 1'b1;
          err_d    = 1'b0;
        end else if (fill_q != '0) begin
          do_pop = 1'b1;
          if (fill_q < CntW'(3) || !kee_pkg::is_op(prev_q) || !kee_pkg::is_op(prev2_q)) begin
            err_d = 1'b0;
          end
        end
      end
      kee_pkg::OpClrErr: err_d = 1'b0;
      kee_pkg::OpRead: rd_en_d = (CntW'(q_entry_i.idx) < fill_q);
      default: ;
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    last_d = last_q;
    if (do_clear) begin
      fill_d = '0;
    end else if (do_push) begin
      fill_d = fill_q + CntW'(1);
      last_d = push_ch;
    end else if (do_pop) begin
      fill_d = fill_q - CntW'(1);
      last_d = prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      shift_q     <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        fill_q  <= fill_d;
        shift_q <= shift_d;
        err_q   <= err_d;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The three newest characters are cached; the fourth is refilled from the buffer.
  always_ff @(posedge clk_i) begin
    if (exec && do_push) begin
      mem[fill_q[AddrW-1:0]] <= push_ch;
    end
    if (exec) begin
      rd_data_q <= mem[q_entry_i.idx];
    end
    if (exec && do_pop) begin
      deep_q <= mem[deep_addr];
    end else if (exec && do_push) begin
      deep_q <= prev2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      last_q      <= last_d;
      out_len_q   <= 6'(fill_d);
      out_last_q  <= (fill_d != '0) ? last_d : 8'd0;
      out_shift_q <= shift_d;
      out_err_q   <= err_d;
      rd_en_q     <= rd_en_d;
      if (do_push) begin
        prev_q  <= last_q;
        prev2_q <= prev_q;
      end else if (do_pop) begin
        prev_q  <= prev2_q;
        prev2_q <= deep_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_length_o    = out_len_q;
  assign out_last_char_o = out_last_q;
  assign out_shift_on_o  = out_shift_q;
  assign out_error_o     = out_err_q;
  assign out_read_char_o = rd_en_q ? rd_data_q : 8'd0;

endmodule

[rtl/keypad_expression_editor.sv]
// Channel  Handshake                 Payload
// in       in_valid_i / in_stall_o   in_cmd_i, in_key_i, in_read_index_i
// out      out_valid_o / out_stall_i out_length_o, out_last_char_o, out_shift_on_o,
//                                    out_error_o, out_read_char_o
//
// One beat is taken every cycle while the queue is not full; the back end executes
// the queue head whenever the output register is empty or not stalled. Each beat is
// written into the queue, then executed by the back end into the output register.
// The two-entry queue lets input beats keep arriving while the output register is stalled.
// Reset clears the fill count, the flags and the queue; buffer contents are not cleared.
`include "assert_macros.svh"

module keypad_expression_editor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] in_cmd_i,
  input  logic [7:0] in_key_i,
  input  logic [4:0] in_read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] out_length_o,
  output logic [7:0] out_last_char_o,
  output logic       out_shift_on_o,
  output logic       out_error_o,
  output logic [7:0] out_read_char_o
);

  logic               q_push, q_pop, q_valid;
  kee_pkg::entry_t    push_entry, head_entry;
  kee_pkg::q_status_t q_status;

  kee_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_cmd_i        (in_cmd_i),
    .in_key_i        (in_key_i),
    .in_read_index_i (in_read_index_i),
    .q_full_i        (q_status.full),
    .q_push_o        (q_push),
    .q_entry_o       (push_entry)
  );

  kee_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .entry_i  (push_entry),
    .pop_i    (q_pop),
    .valid_o  (q_valid),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  kee_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (head_entry),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_length_o    (out_length_o),
    .out_last_char_o (out_last_char_o),
    .out_shift_on_o  (out_shift_on_o),
    .out_error_o     (out_error_o),
    .out_read_char_o (out_read_char_o)
  );

  `KEE_ASSERT(a_queue_grows, (q_push && !q_pop) |=> (q_status.count == $past(q_status.count) + 1))
  `KEE_ASSERT(a_back_flows, (out_valid_o && !out_stall_i && !q_status.empty) |=> out_valid_o)
  `KEE_ASSERT_ALWAYS(a_empty_last, out_valid_o |-> ((out_length_o == 6'd0) == (out_last_char_o == 8'd0)))
  `KEE_ASSERT(a_len_bound, out_valid_o |-> (out_length_o <= 6'd32))

endmodule
